FILE: src/tss_pkg.sv
// Shared widths, codes and types of the time-slice task scheduler.
`default_nettype none

package tss_pkg;

  localparam int TASK_W        = 3;
  localparam int CNT_W         = 9;
  localparam int PRIO_W        = 8;
  localparam int REF_W         = 8;
  localparam int NUM_TASKS_DEF = 8;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic MODE_SHORTEST = 1'b0;
  localparam logic MODE_PRIORITY = 1'b1;

  // One task table entry.
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [PRIO_W-1:0] prio;
    logic [REF_W-1:0]  refill;
  } entry_t;

  // Task table port controls; addresses travel beside it.
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    entry_t wr_data;
  } mem_ctl_t;

  // Verdict on one scanned entry.
  typedef struct packed {
    logic             take;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] key;
  } pick_t;

  // One result transaction.
  typedef struct packed {
    logic [TASK_W-1:0] running_task;
    logic              switched;
    logic              refilled;
    logic              no_ready;
    logic [CNT_W-1:0]  running_counter;
  } res_t;

endpackage

`default_nettype wire

FILE: src/tss_if.sv
// Input and result channel interfaces of the task scheduler.
`default_nettype none

interface tss_in_if import tss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TASK_W-1:0] task_index;
  logic [PRIO_W-1:0] priority_value;
  logic [REF_W-1:0]  refill_value;

  modport source (output valid, command, task_index, priority_value, refill_value,
                  input ready);
  modport sink (input valid, command, task_index, priority_value, refill_value,
                output ready);
endinterface

interface tss_out_if import tss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] running_task;
  logic              switched;
  logic              refilled;
  logic              no_ready;
  logic [CNT_W-1:0]  running_counter;

  modport source (output valid, running_task, switched, refilled, no_ready,
                  running_counter, input ready);
  modport sink (input valid, running_task, switched, refilled, no_ready,
                running_counter, output ready);
endinterface

`default_nettype wire

FILE: src/timeslice_task_scheduler_unit.sv
// A load or a tick that keeps the running task passes S_RDCUR, S_CUR and S_DONE, then the output register.
// A reschedule scans the task table one entry a cycle through the single read port:
// one pass makes NUM_TASKS-1 reads, two passes when a refill is needed;
// one transaction is in work at a time.
// The next input is taken once the result has moved into the output register.
// Reset: synchronous, active low; table valid bits clear at once, no clearing pass.
`default_nettype none

module timeslice_task_scheduler_unit import tss_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  tss_in_if.sink    in_ch,
  tss_out_if.source out_ch
);

  localparam int AW = $clog2(NUM_TASKS);

  logic          policy_mode_r;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        rd_data;
  res_t          res;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_mode_r <= MODE_SHORTEST;
    end else if (cfg_we) begin
      policy_mode_r <= cfg_wdata;
    end
  end

  tss_mem #(
    .DEPTH (NUM_TASKS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .waddr   (mem_waddr),
    .raddr   (mem_raddr),
    .rd_data (rd_data)
  );

  tss_seq #(
    .NUM_TASKS (NUM_TASKS),
    .AW        (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (policy_mode_r),
    .in_ch     (in_ch),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // Output register: load when empty or being drained.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.running_task    = out_res_r.running_task;
  assign out_ch.switched        = out_res_r.switched;
  assign out_ch.refilled        = out_res_r.refilled;
  assign out_ch.no_ready        = out_res_r.no_ready;
  assign out_ch.running_counter = out_res_r.running_counter;

endmodule

`default_nettype wire

FILE: src/tss_mem.sv
// Task table memory: one write and one registered read per cycle, per-entry valid bits.
`default_nettype none

module tss_mem import tss_pkg::*; #(
  parameter int DEPTH = NUM_TASKS_DEF,
  parameter int AW    = $clog2(NUM_TASKS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mem_ctl_t      ctl,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rd_data
);

  entry_t           mem_r [DEPTH];
  entry_t           rd_q_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[waddr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem_r[raddr];
    end
  end

  // Entries never written read as zero, the reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

FILE: src/tss_pick.sv
// Per-entry selection compare and refill/decay arithmetic for the table scan.
`default_nettype none

module tss_pick import tss_pkg::*; (
  input  wire logic             mode,
  input  wire logic             refill_pass,
  input  wire entry_t           ent,
  input  wire logic             found,
  input  wire logic [CNT_W-1:0] best_key,
  output pick_t                 pk
);

  logic [CNT_W-1:0] refill_cnt;
  logic [CNT_W-1:0] cnt_eval;
  logic [CNT_W-1:0] prio_x;

  assign prio_x = CNT_W'(ent.prio);

  always_comb begin
    if (mode == MODE_SHORTEST) begin
      refill_cnt = CNT_W'(ent.refill);
    end else begin
      refill_cnt = CNT_W'(ent.cnt[CNT_W-1:1]) + prio_x;
    end
  end

  assign cnt_eval = refill_pass ? refill_cnt : ent.cnt;

  // Scan runs upward, so ties compare with <= / >= to favor the higher index.
  always_comb begin
    pk.cnt = cnt_eval;
    if (mode == MODE_SHORTEST) begin
      pk.key  = cnt_eval;
      pk.take = (cnt_eval != '0) && (!found || cnt_eval <= best_key);
    end else begin
      pk.key  = prio_x;
      pk.take = (cnt_eval != '0) && (ent.prio != '0) && (!found || prio_x >= best_key);
    end
  end

endmodule

`default_nettype wire

FILE: src/tss_seq.sv
// Sequencer: read-modify-write of the task table and the two-pass reschedule scan.
`default_nettype none

module tss_seq import tss_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int AW        = $clog2(NUM_TASKS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          mode,
  tss_in_if.sink             in_ch,
  output mem_ctl_t           mem_ctl,
  output logic [AW-1:0]      mem_waddr,
  output logic [AW-1:0]      mem_raddr,
  input  wire entry_t        rd_data,
  output res_t               res,
  output logic               res_valid,
  input  wire logic          res_ready
);

  localparam int            XW       = (AW > TASK_W) ? AW : TASK_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TASKS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RDCUR = 5'b00010,
    S_CUR   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic              cmd_r, cmd_nxt;
  logic [TASK_W-1:0] cur_r, cur_nxt;
  logic [AW-1:0]     scan_addr_r, scan_addr_nxt;
  logic              issue_r, issue_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              rd_chk_r, rd_chk_nxt;
  logic              pass_r, pass_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]  best_key_r, best_key_nxt;
  logic [CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  res_t              res_r, res_nxt;

  logic              start_scan;
  logic              start_refill;
  logic [XW-1:0]     cur_x;
  logic [AW-1:0]     cur_addr;
  logic [XW-1:0]     idx_x;
  logic [AW-1:0]     load_addr;
  logic              load_ok;
  logic [CNT_W-1:0]  dec_cnt;
  pick_t             pk;
  logic              fin_found;
  logic [AW-1:0]     fin_idx;
  logic [CNT_W-1:0]  fin_cnt;
  logic [XW-1:0]     fin_x;
  logic [TASK_W-1:0] fin_task;

  assign cur_x     = XW'(cur_r);
  assign cur_addr  = cur_x[AW-1:0];
  assign idx_x     = XW'(in_ch.task_index);
  assign load_addr = idx_x[AW-1:0];
  assign load_ok   = (in_ch.task_index != '0) && (int'(in_ch.task_index) < NUM_TASKS);
  assign dec_cnt   = (rd_data.cnt == '0) ? '0 : rd_data.cnt - CNT_W'(1);

  tss_pick u_pick (
    .mode        (mode),
    .refill_pass (pass_r),
    .ent         (rd_data),
    .found       (best_idx_r != '0),
    .best_key    (best_key_r),
    .pk          (pk)
  );

  assign fin_found = pk.take || (best_idx_r != '0);
  assign fin_idx   = pk.take ? rd_idx_r : best_idx_r;
  assign fin_cnt   = pk.take ? pk.cnt : best_cnt_r;
  assign fin_x     = XW'(fin_idx);
  assign fin_task  = fin_x[TASK_W-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cur_nxt       = cur_r;
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    rd_idx_nxt    = rd_idx_r;
    rd_chk_nxt    = 1'b0;
    pass_nxt      = pass_r;
    best_idx_nxt  = best_idx_r;
    best_key_nxt  = best_key_r;
    best_cnt_nxt  = best_cnt_r;
    res_nxt       = res_r;
    start_scan    = 1'b0;
    start_refill  = 1'b0;
    mem_ctl       = '0;
    mem_waddr     = '0;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.command;
          if (in_ch.command == CMD_LOAD) begin
            if (load_ok) begin
              mem_ctl.wr_en          = 1'b1;
              mem_waddr              = load_addr;
              mem_ctl.wr_data.cnt    = '0;
              mem_ctl.wr_data.prio   = in_ch.priority_value;
              mem_ctl.wr_data.refill = in_ch.refill_value;
            end
            state_nxt = S_RDCUR;
          end else if (cur_r == '0) begin
            start_scan = 1'b1;
          end else begin
            state_nxt = S_RDCUR;
          end
        end
      end

      S_RDCUR: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = cur_addr;
        state_nxt     = S_CUR;
      end

      S_CUR: begin
        if (cmd_r == CMD_LOAD) begin
          res_nxt   = '{running_task: cur_r, switched: 1'b0, refilled: 1'b0,
                        no_ready: 1'b0, running_counter: rd_data.cnt};
          state_nxt = S_DONE;
        end else begin
          // Saturating decrement, written back before any scan read.
          mem_ctl.wr_en       = 1'b1;
          mem_waddr           = cur_addr;
          mem_ctl.wr_data     = rd_data;
          mem_ctl.wr_data.cnt = dec_cnt;
          if (dec_cnt == '0) begin
            start_scan = 1'b1;
          end else begin
            res_nxt   = '{running_task: cur_r, switched: 1'b0, refilled: 1'b0,
                          no_ready: 1'b0, running_counter: dec_cnt};
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (issue_r) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = scan_addr_r;
          rd_idx_nxt    = scan_addr_r;
          rd_chk_nxt    = 1'b1;
          if (scan_addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + AW'(1);
          end
        end
        if (rd_chk_r) begin
          // Refill pass: write the new counter back and judge it in the same cycle.
          if (pass_r) begin
            mem_ctl.wr_en       = 1'b1;
            mem_waddr           = rd_idx_r;
            mem_ctl.wr_data     = rd_data;
            mem_ctl.wr_data.cnt = pk.cnt;
          end
          if (pk.take) begin
            best_idx_nxt = rd_idx_r;
            best_key_nxt = pk.key;
            best_cnt_nxt = pk.cnt;
          end
          if (rd_idx_r == LAST_IDX) begin
            if (fin_found) begin
              res_nxt   = '{running_task: fin_task, switched: (fin_task != cur_r),
                            refilled: pass_r, no_ready: 1'b0, running_counter: fin_cnt};
              cur_nxt   = fin_task;
              state_nxt = S_DONE;
            end else if (!pass_r) begin
              start_scan   = 1'b1;
              start_refill = 1'b1;
            end else begin
              res_nxt   = '{running_task: '0, switched: (cur_r != '0), refilled: 1'b1,
                            no_ready: 1'b1, running_counter: '0};
              cur_nxt   = '0;
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start_scan) begin
      state_nxt     = S_SCAN;
      scan_addr_nxt = AW'(1);
      issue_nxt     = 1'b1;
      rd_chk_nxt    = 1'b0;
      pass_nxt      = start_refill;
      best_idx_nxt  = '0;
      best_key_nxt  = '0;
      best_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= '0;
      issue_r  <= 1'b0;
      rd_chk_r <= 1'b0;
      pass_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      issue_r  <= issue_nxt;
      rd_chk_r <= rd_chk_nxt;
      pass_r   <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_key_r  <= best_key_nxt;
    best_cnt_r  <= best_cnt_nxt;
    res_r       <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: src/tss_checker.sv
// Port-level assertions for the task scheduler and their bind to the top level.
`default_nettype none

module tss_checker import tss_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [TASK_W-1:0] running_task,
  input wire logic              switched,
  input wire logic              refilled,
  input wire logic              no_ready,
  input wire logic [CNT_W-1:0]  running_counter
);

  // One transaction in work at a time: input closes right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(running_task) && $stable(switched)
      && $stable(refilled) && $stable(no_ready) && $stable(running_counter))
    else $error("stalled result changed");

  a_no_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_ready |-> refilled && running_task == '0 && running_counter == '0)
    else $error("no_ready result not idle after refill");

  a_switch_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && switched && !no_ready |-> running_task != '0 && running_counter != '0)
    else $error("switched to a task with no slice left");

endmodule

bind timeslice_task_scheduler_unit tss_checker u_tss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .running_task    (out_ch.running_task),
  .switched        (out_ch.switched),
  .refilled        (out_ch.refilled),
  .no_ready        (out_ch.no_ready),
  .running_counter (out_ch.running_counter)
);

`default_nettype wire

FILE: tb/sv/timeslice_task_scheduler_unit_test.sv
// Self-checking testbench for the time-slice task scheduler unit.
`timescale 1ns / 1ps

module timeslice_task_scheduler_unit_test;
  import tss_pkg::*;

  localparam int NUM_TASKS = NUM_TASKS_DEF;

  typedef struct packed {
    logic              command;
    logic [TASK_W-1:0] task_index;
    logic [PRIO_W-1:0] priority_value;
    logic [REF_W-1:0]  refill_value;
  } sched_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  tss_in_if  in_ch ();
  tss_out_if out_ch ();

  timeslice_task_scheduler_unit #(.NUM_TASKS(NUM_TASKS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Scheduler state as the block should hold it.
  logic [CNT_W-1:0]  slice_cnt  [NUM_TASKS];
  logic [PRIO_W-1:0] prio_tbl   [NUM_TASKS];
  logic [REF_W-1:0]  refill_tbl [NUM_TASKS];
  logic [TASK_W-1:0] cur_task;
  logic              policy;

  sched_cmd_t pending_cmds [$];
  res_t       expected_sched [$];

  sched_cmd_t drv_cmd;
  res_t       exp_res;
  res_t       got_res;
  logic       in_taken;
  int         in_idle_pct;
  int         out_idle_pct;
  int         mismatch_count;

  function automatic logic [TASK_W-1:0] select_task();
    logic [TASK_W-1:0] best;
    logic [CNT_W-1:0]  key;
    best = '0;
    key  = '0;
    // Scan from the top so ties keep the highest index.
    for (int i = NUM_TASKS - 1; i > 0; i--) begin
      if (slice_cnt[i] != 0) begin
        if (policy == MODE_SHORTEST) begin
          if (key == 0 || slice_cnt[i] < key) begin
            key  = slice_cnt[i];
            best = TASK_W'(i);
          end
        end else if (CNT_W'(prio_tbl[i]) > key) begin
          key  = CNT_W'(prio_tbl[i]);
          best = TASK_W'(i);
        end
      end
    end
    return best;
  endfunction

  function automatic res_t schedule_step(sched_cmd_t c);
    res_t              r;
    logic [TASK_W-1:0] prev;
    logic [TASK_W-1:0] nxt;
    logic              resched;
    r       = '0;
    resched = 1'b0;
    prev    = cur_task;
    if (c.command == CMD_LOAD) begin
      if (c.task_index != 0 && c.task_index < NUM_TASKS) begin
        prio_tbl[c.task_index]   = c.priority_value;
        refill_tbl[c.task_index] = c.refill_value;
        slice_cnt[c.task_index]  = '0;
      end
    end else if (cur_task == 0) begin
      resched = 1'b1;
    end else begin
      if (slice_cnt[cur_task] != 0) slice_cnt[cur_task] = slice_cnt[cur_task] - 1'b1;
      if (slice_cnt[cur_task] == 0) resched = 1'b1;
    end
    if (resched) begin
      nxt = select_task();
      if (nxt == 0) begin
        // One refill or decay pass, idle slot skipped.
        for (int i = 1; i < NUM_TASKS; i++) begin
          if (policy == MODE_SHORTEST) slice_cnt[i] = CNT_W'(refill_tbl[i]);
          else slice_cnt[i] = CNT_W'((slice_cnt[i] >> 1) + prio_tbl[i]);
        end
        r.refilled = 1'b1;
        nxt = select_task();
        r.no_ready = (nxt == 0);
      end
      r.switched = (nxt != prev);
      cur_task   = nxt;
    end
    r.running_task    = cur_task;
    r.running_counter = slice_cnt[cur_task];
    return r;
  endfunction

  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    c.command    = ($urandom_range(99) < 30) ? CMD_LOAD : CMD_TICK;
    c.task_index = TASK_W'($urandom_range(NUM_TASKS - 1));
    // Keep slices mostly short so rescheduling happens often.
    case ($urandom_range(9))
      0:       c.priority_value = PRIO_W'($urandom_range(255));
      1:       c.priority_value = '0;
      default: c.priority_value = PRIO_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(9))
      0:       c.refill_value = REF_W'($urandom_range(255));
      1:       c.refill_value = '0;
      default: c.refill_value = REF_W'($urandom_range(1, 8));
    endcase
    return c;
  endfunction

  task automatic queue_cmd(input logic cmd, input int idx, input int prio, input int refv);
    sched_cmd_t c;
    c.command        = cmd;
    c.task_index     = TASK_W'(idx);
    c.priority_value = PRIO_W'(prio);
    c.refill_value   = REF_W'(refv);
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_sched.size() != 0)
      @(posedge clk);
    repeat (2 * NUM_TASKS + 8) @(posedge clk);
  endtask

  task automatic write_policy(input logic mode);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Predict on every accepted transaction and track register writes.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        slice_cnt[i]  = '0;
        prio_tbl[i]   = '0;
        refill_tbl[i] = '0;
      end
      cur_task = '0;
      policy   = MODE_SHORTEST;
      in_taken = 1'b0;
    end else begin
      if (cfg_we) policy = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        expected_sched.push_back(schedule_step({in_ch.command, in_ch.task_index,
                                                in_ch.priority_value, in_ch.refill_value}));
      end
    end
  end

  // Driver: advance to the next command once the current one is taken.
  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (rst_n && pending_cmds.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        drv_cmd = pending_cmds.pop_front();
        in_ch.command        <= drv_cmd.command;
        in_ch.task_index     <= drv_cmd.task_index;
        in_ch.priority_value <= drv_cmd.priority_value;
        in_ch.refill_value   <= drv_cmd.refill_value;
        in_ch.valid          <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Monitor: check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res = {out_ch.running_task, out_ch.switched, out_ch.refilled, out_ch.no_ready,
                 out_ch.running_counter};
      if (expected_sched.size() == 0) begin
        $display("%0t: result with nothing expected, task %0d counter %0d", $time,
                 got_res.running_task, got_res.running_counter);
        mismatch_count++;
      end else begin
        exp_res = expected_sched.pop_front();
        if (got_res.running_task !== exp_res.running_task) begin
          $display("%0t: running_task expected %0d got %0d", $time,
                   exp_res.running_task, got_res.running_task);
          mismatch_count++;
        end
        if (got_res.switched !== exp_res.switched) begin
          $display("%0t: switched expected %0b got %0b", $time,
                   exp_res.switched, got_res.switched);
          mismatch_count++;
        end
        if (got_res.refilled !== exp_res.refilled) begin
          $display("%0t: refilled expected %0b got %0b", $time,
                   exp_res.refilled, got_res.refilled);
          mismatch_count++;
        end
        if (got_res.no_ready !== exp_res.no_ready) begin
          $display("%0t: no_ready expected %0b got %0b", $time,
                   exp_res.no_ready, got_res.no_ready);
          mismatch_count++;
        end
        if (got_res.running_counter !== exp_res.running_counter) begin
          $display("%0t: running_counter expected %0d got %0d", $time,
                   exp_res.running_counter, got_res.running_counter);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_TICK;
    in_ch.task_index     = '0;
    in_ch.priority_value = '0;
    in_ch.refill_value   = '0;
    out_ch.ready         = 1'b0;
    in_taken             = 1'b0;
    mismatch_count       = 0;
    in_idle_pct          = 15;
    out_idle_pct         = 86;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Shortest-job mode from reset: empty table, ignored idle load, ties, saturation.
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_LOAD, 0, 255, 255);
    queue_cmd(CMD_LOAD, 7, 255, 255);
    queue_cmd(CMD_LOAD, 1, 0, 1);
    queue_cmd(CMD_LOAD, 2, 3, 0);
    queue_cmd(CMD_TICK, 5, 170, 85);
    queue_cmd(CMD_TICK, 2, 85, 170);
    queue_cmd(CMD_LOAD, 7, 128, 1);
    queue_cmd(CMD_TICK, 7, 255, 255);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    drain();
    write_policy(MODE_PRIORITY);

    // Priority mode: decay, equal priorities, zero priority, nothing ready.
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_LOAD, 4, 3, 0);
    queue_cmd(CMD_LOAD, 5, 3, 0);
    queue_cmd(CMD_LOAD, 7, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_LOAD, 2, 0, 0);
    queue_cmd(CMD_LOAD, 4, 0, 0);
    queue_cmd(CMD_LOAD, 5, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_LOAD, 6, 255, 255);
    queue_cmd(CMD_TICK, 0, 0, 0);
    drain();

    // Random chunks: alternate policy, change idling every two chunks.
    for (int chunk = 0; chunk < 6; chunk++) begin
      if (chunk / 2 == 1) begin
        in_idle_pct  = 86;
        out_idle_pct = 15;
      end else if (chunk / 2 == 2) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      write_policy((chunk % 2 == 0) ? MODE_SHORTEST : MODE_PRIORITY);
      repeat (75) pending_cmds.push_back(rand_cmd());
      drain();
    end

    if (mismatch_count == 0 && expected_sched.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
